/* rtl/intrusion_alarm_controller_defines.svh */
// Assertion macros shared by the intrusion alarm controller RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef INTRUSION_ALARM_CONTROLLER_DEFINES_SVH
`define INTRUSION_ALARM_CONTROLLER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define IAC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define IAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/iac_pkg.sv */
// Package for the intrusion alarm controller: command codes, register
// indexes, reset values and the item, result and config structs.
`timescale 1ns / 1ps

package iac_pkg;

	// event commands
	localparam logic [1:0] CMD_LINE   = 2'd0;
	localparam logic [1:0] CMD_MOTION = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// configuration register indexes
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_PERIOD   = 1'b1;

	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [7:0]  PERIOD_RESET   = 8'd5;

	typedef struct packed {
		logic [1:0]  command;
		logic        arm_line;
		logic        door_line;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        armed_now;
		logic        door_is_open;
		logic        alarm_on;
		logic        alarm_raised;
		logic        heartbeat_level;
		logic        status_due;
		logic [31:0] uptime_s;
	} result_t;

	typedef struct packed {
		logic [15:0] debounce_window_ms;
		logic [7:0]  status_period_ticks;
	} cfg_t;

endpackage

/* rtl/iac_ifs.sv */
// Valid/ready channel interfaces for event items and result items.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface iac_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic        arm_line;
	logic        door_line;
	logic [31:0] now_ms;

	modport source (output valid, command, arm_line, door_line, now_ms, input ready);
	modport sink (input valid, command, arm_line, door_line, now_ms, output ready);
endinterface

interface iac_result_if;
	logic        valid;
	logic        ready;
	logic        armed_now;
	logic        door_is_open;
	logic        alarm_on;
	logic        alarm_raised;
	logic        heartbeat_level;
	logic        status_due;
	logic [31:0] uptime_s;

	modport source (output valid, armed_now, door_is_open, alarm_on, alarm_raised,
		heartbeat_level, status_due, uptime_s, input ready);
	modport sink (input valid, armed_now, door_is_open, alarm_on, alarm_raised,
		heartbeat_level, status_due, uptime_s, output ready);
endinterface

/* rtl/iac_cfg.sv */
// Configuration registers of the alarm controller (debounce window, status period).
// Depends on iac_pkg.
`timescale 1ns / 1ps

module iac_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [iac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output iac_pkg::cfg_t                 cfg
);

	logic [15:0] debounce_q;
	logic [7:0]  period_q;

	// register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= iac_pkg::DEBOUNCE_RESET;
			period_q   <= iac_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				iac_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata[15:0];
				iac_pkg::REG_PERIOD:   period_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.debounce_window_ms  = debounce_q;
	assign cfg.status_period_ticks = period_q;

endmodule

/* rtl/iac_core.sv */
// Alarm state registers and the per-item update logic.
// Depends on iac_pkg and intrusion_alarm_controller_defines.svh.
`timescale 1ns / 1ps
`include "intrusion_alarm_controller_defines.svh"

module iac_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  iac_pkg::item_t   item,
	input  iac_pkg::cfg_t    cfg,
	output iac_pkg::result_t result
);

	logic        armed_q, alarm_q, door_q, heartbeat_q;
	logic [1:0]  lines_q;
	logic [31:0] arm_time_q, door_time_q, seconds_q;
	logic [7:0]  status_q;

	logic        is_line, is_motion, is_tick;
	logic [1:0]  lines, changed;
	logic [31:0] arm_dt, door_dt, window;
	logic        arm_ok, door_ok;
	logic        armed_n, door_n, alarm_n, heartbeat_n, due;
	logic [31:0] seconds_n;
	logic [7:0]  status_inc, status_n;

	// decode and debounce
	always_comb begin
		is_line   = (item.command == iac_pkg::CMD_LINE);
		is_motion = (item.command == iac_pkg::CMD_MOTION);
		is_tick   = (item.command == iac_pkg::CMD_TICK);
		lines     = {item.door_line, item.arm_line};
		changed   = lines ^ lines_q;
		window    = {16'd0, cfg.debounce_window_ms};
		arm_dt    = item.now_ms - arm_time_q;
		door_dt   = item.now_ms - door_time_q;
		arm_ok    = is_line && changed[0] && !item.arm_line && (arm_dt > window);
		door_ok   = is_line && changed[1] && !item.door_line && (door_dt > window);
	end

	// next state; arm press is applied before door press
	always_comb begin
		armed_n = armed_q ^ arm_ok;
		door_n  = door_q ^ door_ok;
		alarm_n = alarm_q;
		if (arm_ok && !armed_n)
			alarm_n = 1'b0;
		if (door_ok && armed_n && door_n)
			alarm_n = 1'b1;
		if (is_motion && armed_q)
			alarm_n = 1'b1;

		status_inc  = status_q + 8'd1;
		due         = is_tick && (status_inc >= cfg.status_period_ticks);
		status_n    = status_q;
		heartbeat_n = heartbeat_q;
		seconds_n   = seconds_q;
		if (is_tick) begin
			status_n    = due ? 8'd0 : status_inc;
			heartbeat_n = !heartbeat_q;
			seconds_n   = seconds_q + 32'd1;
		end
	end

	// state update on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			alarm_q     <= 1'b0;
			door_q      <= 1'b0;
			heartbeat_q <= 1'b0;
			lines_q     <= 2'b11;
			arm_time_q  <= 32'd0;
			door_time_q <= 32'd0;
			seconds_q   <= 32'd0;
			status_q    <= 8'd0;
		end else if (fire) begin
			armed_q     <= armed_n;
			alarm_q     <= alarm_n;
			door_q      <= door_n;
			heartbeat_q <= heartbeat_n;
			seconds_q   <= seconds_n;
			status_q    <= status_n;
			if (is_line)
				lines_q <= lines;
			if (arm_ok)
				arm_time_q <= item.now_ms;
			if (door_ok)
				door_time_q <= item.now_ms;
		end
	end

	assign result.armed_now       = armed_n;
	assign result.door_is_open    = door_n;
	assign result.alarm_on        = alarm_n;
	assign result.alarm_raised    = alarm_n && !alarm_q;
	assign result.heartbeat_level = heartbeat_n;
	assign result.status_due      = due;
	assign result.uptime_s        = seconds_n;

	// alarm can only be latched while armed, and disarming clears it
	`IAC_ASSERT_ALWAYS(a_alarm_needs_armed, !alarm_q || armed_q, "alarm on while disarmed")
	// each processed tick flips the heartbeat
	`IAC_ASSERT_NEXT(a_tick_heartbeat, fire && is_tick, heartbeat_q != $past(heartbeat_q),
		"heartbeat did not toggle on tick")
	// uptime moves only on ticks
	`IAC_ASSERT_NEXT(a_uptime_only_tick, !(fire && is_tick), $stable(seconds_q),
		"uptime changed without a tick")

endmodule

/* rtl/intrusion_alarm_controller.sv */
// An accepted item passes through the input register and then the result register to its result.
// Throughput: one item per cycle; a full result register stalls the input while rsp.ready is low.
// The debounce subtract-and-compare and the flag updates finish between the two registers.
// Reset (arst_n low, asynchronous): disarmed, alarm off, door closed, both lines released,
// counters and press times zero, debounce window 50 ms, status period 5 ticks.
`timescale 1ns / 1ps

module intrusion_alarm_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	iac_event_if.sink                      req,
	iac_result_if.source                   rsp,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [iac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	iac_pkg::cfg_t    cfg;
	iac_pkg::item_t   item_s1;
	iac_pkg::result_t res_next, res_s2;
	logic             valid_s1, valid_s2;
	logic             adv_s1, fire_s1, take_in;

	// handshake: stage 1 moves when the result register is free or being drained
	assign adv_s1    = !valid_s2 || rsp.ready;
	assign fire_s1   = valid_s1 && adv_s1;
	assign req.ready = !valid_s1 || adv_s1;
	assign take_in   = req.valid && req.ready;

	iac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	iac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.command   <= req.command;
			item_s1.arm_line  <= req.arm_line;
			item_s1.door_line <= req.door_line;
			item_s1.now_ms    <= req.now_ms;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire_s1)
			res_s2 <= res_next;
	end

	assign rsp.valid           = valid_s2;
	assign rsp.armed_now       = res_s2.armed_now;
	assign rsp.door_is_open    = res_s2.door_is_open;
	assign rsp.alarm_on        = res_s2.alarm_on;
	assign rsp.alarm_raised    = res_s2.alarm_raised;
	assign rsp.heartbeat_level = res_s2.heartbeat_level;
	assign rsp.status_due      = res_s2.status_due;
	assign rsp.uptime_s        = res_s2.uptime_s;

endmodule

/* verif/tb_intrusion_alarm_controller.sv */
// Self-checking testbench for intrusion_alarm_controller: directed event table,
// then random event phases under several register settings and idle patterns.
// Depends on rtl/iac_pkg.sv, rtl/iac_ifs.sv and the controller RTL.
`timescale 1ns / 1ps

module tb_intrusion_alarm_controller;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int N_DIRECTED     = 24;
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 170;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// one directed row: event, whether the result is typed in, and that result
	typedef struct packed {
		iac_pkg::item_t   ev;
		logic             typed;
		iac_pkg::result_t want;
	} vector_t;

	typedef struct packed {
		logic             typed;
		iac_pkg::result_t want;
	} tag_t;

	localparam iac_pkg::result_t NO_WANT = '0;

	// want columns: armed, door, alarm, raised, heartbeat, due | uptime
	localparam vector_t DIRECTED [N_DIRECTED] = '{
		'{{CMD_UNUSED, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b1, {6'b000000, 32'd0}},
		'{{iac_pkg::CMD_TICK,   1'b1, 1'b1, 32'd0},         1'b1, {6'b000010, 32'd1}},
		'{{iac_pkg::CMD_MOTION, 1'b1, 1'b1, 32'd0},         1'b1, {6'b000010, 32'd1}},
		// arm press exactly at the window edge is bounced
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'd50},        1'b1, {6'b000010, 32'd1}},
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'd60},        1'b1, {6'b000010, 32'd1}},
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'd51},        1'b1, {6'b100010, 32'd1}},
		// door opens while armed
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b0, 32'd200},       1'b1, {6'b111110, 32'd1}},
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b0, 32'd300},       1'b1, {6'b010010, 32'd1}},
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'd310},       1'b1, {6'b010010, 32'd1}},
		// arming with the door already open does not raise the alarm
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'd400},       1'b1, {6'b110010, 32'd1}},
		'{{iac_pkg::CMD_MOTION, 1'b0, 1'b0, 32'd0},         1'b1, {6'b111110, 32'd1}},
		'{{iac_pkg::CMD_MOTION, 1'b1, 1'b0, 32'd7},         1'b1, {6'b111010, 32'd1}},
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'd410},       1'b1, {6'b111010, 32'd1}},
		// both lines pressed together: disarm, then door closes
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b0, 32'd500},       1'b1, {6'b000010, 32'd1}},
		'{{iac_pkg::CMD_TICK,   1'b0, 1'b1, 32'd0},         1'b0, NO_WANT},
		'{{iac_pkg::CMD_TICK,   1'b1, 1'b0, 32'd0},         1'b0, NO_WANT},
		'{{iac_pkg::CMD_TICK,   1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
		'{{iac_pkg::CMD_TICK,   1'b1, 1'b1, 32'd0},         1'b0, NO_WANT},
		// timestamp wrap around the debounce window
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'hFFFF_FFF0}, 1'b0, NO_WANT},
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'd5},         1'b0, NO_WANT},
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'h20},        1'b0, NO_WANT},
		'{{iac_pkg::CMD_LINE,   1'b1, 1'b1, 32'h21},        1'b0, NO_WANT},
		'{{iac_pkg::CMD_LINE,   1'b0, 1'b1, 32'h23},        1'b0, NO_WANT}
	};

	// random phases: register setting and idle percentages per phase
	localparam int PH_WINDOW [N_PHASES] = '{50, 0, 65535, 333, 1000, 20};
	localparam int PH_PERIOD [N_PHASES] = '{5, 1, 255, 0, 3, 2};
	localparam int PH_TX_IDLE [N_PHASES] = '{31, 31, 54, 54, 0, 0};
	localparam int PH_RX_IDLE [N_PHASES] = '{54, 54, 31, 31, 0, 0};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [iac_pkg::CFG_DATA_W-1:0] cfg_wdata;

	iac_event_if  req_if ();
	iac_result_if rsp_if ();

	intrusion_alarm_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the controller state and registers
	logic [15:0] pred_window;
	logic [7:0]  pred_period;
	logic        pred_armed;
	logic        pred_alarm;
	logic        pred_door;
	logic        pred_heartbeat;
	logic [1:0]  pred_lines;
	logic [31:0] pred_arm_time;
	logic [31:0] pred_door_time;
	logic [31:0] pred_uptime;
	logic [7:0]  pred_status_cnt;

	iac_pkg::result_t status_q [$];
	tag_t             tag_q [$];

	int tx_idle;
	int rx_idle;
	int n_fail;
	int n_items;
	int n_results;
	int n_raised;
	int n_due;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// apply one event to the predicted state, return the status it reports
	function automatic iac_pkg::result_t advance_alarm(iac_pkg::item_t ev);
		iac_pkg::result_t r;
		logic             was_alarm;
		logic [1:0]       changed;
		r = '0;
		was_alarm = pred_alarm;
		case (ev.command)
			iac_pkg::CMD_LINE: begin
				changed = {ev.door_line, ev.arm_line} ^ pred_lines;
				if (changed[0] && !ev.arm_line
						&& (ev.now_ms - pred_arm_time) > {16'd0, pred_window}) begin
					pred_arm_time = ev.now_ms;
					pred_armed = !pred_armed;
					if (!pred_armed)
						pred_alarm = 1'b0;
				end
				if (changed[1] && !ev.door_line
						&& (ev.now_ms - pred_door_time) > {16'd0, pred_window}) begin
					pred_door_time = ev.now_ms;
					pred_door = !pred_door;
					if (pred_armed && pred_door)
						pred_alarm = 1'b1;
				end
				pred_lines = {ev.door_line, ev.arm_line};
			end
			iac_pkg::CMD_MOTION: begin
				if (pred_armed)
					pred_alarm = 1'b1;
			end
			iac_pkg::CMD_TICK: begin
				pred_uptime = pred_uptime + 32'd1;
				pred_heartbeat = !pred_heartbeat;
				pred_status_cnt = pred_status_cnt + 8'd1;
				if (pred_status_cnt >= pred_period) begin
					pred_status_cnt = '0;
					r.status_due = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.armed_now = pred_armed;
		r.door_is_open = pred_door;
		r.alarm_on = pred_alarm;
		r.alarm_raised = !was_alarm && pred_alarm;
		r.heartbeat_level = pred_heartbeat;
		r.uptime_s = pred_uptime;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		n_fail++;
		$display("%0t ERROR %s", $time, what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
				n_results, name, got, want));
	endtask

	// receiver: random back-pressure on the result channel
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// monitor: predict on each accepted event, check each accepted result, watchdog
	always @(posedge clk) begin : monitor
		iac_pkg::item_t   ev;
		tag_t             tag;
		iac_pkg::result_t want;
		iac_pkg::result_t got;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				ev = {req_if.command, req_if.arm_line, req_if.door_line, req_if.now_ms};
				want = advance_alarm(ev);
				tag = tag_q.pop_front();
				if (tag.typed)
					want = tag.want;
				status_q.push_back(want);
				n_items++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got = {rsp_if.armed_now, rsp_if.door_is_open, rsp_if.alarm_on,
					rsp_if.alarm_raised, rsp_if.heartbeat_level, rsp_if.status_due,
					rsp_if.uptime_s};
				n_results++;
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						n_results));
				end else begin
					want = status_q.pop_front();
					check_field("armed_now", 32'(got.armed_now), 32'(want.armed_now));
					check_field("door_is_open", 32'(got.door_is_open),
						32'(want.door_is_open));
					check_field("alarm_on", 32'(got.alarm_on), 32'(want.alarm_on));
					check_field("alarm_raised", 32'(got.alarm_raised),
						32'(want.alarm_raised));
					check_field("heartbeat_level", 32'(got.heartbeat_level),
						32'(want.heartbeat_level));
					check_field("status_due", 32'(got.status_due), 32'(want.status_due));
					check_field("uptime_s", got.uptime_s, want.uptime_s);
					n_raised += int'(want.alarm_raised);
					n_due += int'(want.status_due);
				end
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $time, stall_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// drive one event item; valid stays high when the next item follows at once
	task automatic send_event(iac_pkg::item_t ev, logic typed, iac_pkg::result_t want);
		if ($urandom_range(0, 99) < tx_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle)
				@(posedge clk);
		end
		tag_q.push_back({typed, want});
		req_if.valid <= 1'b1;
		req_if.command <= ev.command;
		req_if.arm_line <= ev.arm_line;
		req_if.door_line <= ev.door_line;
		req_if.now_ms <= ev.now_ms;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	// write both registers back to back while the block is idle
	task automatic program_regs(logic [15:0] window, logic [7:0] period);
		cfg_we <= 1'b1;
		cfg_index <= iac_pkg::REG_DEBOUNCE;
		cfg_wdata <= window;
		@(posedge clk);
		// upper byte is don't-care for the period register
		cfg_index <= iac_pkg::REG_PERIOD;
		cfg_wdata <= {8'($urandom_range(0, 255)), period};
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_window = window;
		pred_period = period;
	endtask

	// random events: line changes most often, on a running clock, some near window
	task automatic run_random(int count);
		iac_pkg::item_t ev;
		int             pick;
		logic [31:0]    stamp;
		stamp = $urandom;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			ev.arm_line = 1'($urandom_range(0, 1));
			ev.door_line = 1'($urandom_range(0, 1));
			ev.now_ms = $urandom;
			if (pick < 45) begin
				ev.command = iac_pkg::CMD_LINE;
				if (pick >= 12) begin
					stamp = stamp + $urandom_range(0, int'(pred_window) * 3 / 2 + 20);
					ev.now_ms = stamp;
				end else if (pick >= 5) begin
					// land on or just past the debounce edge of the pressed line
					ev.now_ms = (ev.arm_line ? pred_door_time : pred_arm_time)
						+ {16'd0, pred_window} + $urandom_range(0, 1);
				end
			end else if (pick < 65) begin
				ev.command = iac_pkg::CMD_MOTION;
			end else if (pick < 93) begin
				ev.command = iac_pkg::CMD_TICK;
			end else begin
				ev.command = CMD_UNUSED;
			end
			send_event(ev, 1'b0, NO_WANT);
		end
	endtask

	// main sequence: reset, directed table, random phases, final verdict
	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= iac_pkg::REG_DEBOUNCE;
		cfg_wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.command <= iac_pkg::CMD_LINE;
		req_if.arm_line <= 1'b1;
		req_if.door_line <= 1'b1;
		req_if.now_ms <= '0;
		pred_window = iac_pkg::DEBOUNCE_RESET;
		pred_period = iac_pkg::PERIOD_RESET;
		pred_armed = 1'b0;
		pred_alarm = 1'b0;
		pred_door = 1'b0;
		pred_heartbeat = 1'b0;
		pred_lines = 2'b11;
		pred_arm_time = '0;
		pred_door_time = '0;
		pred_uptime = '0;
		pred_status_cnt = '0;
		tx_idle = PH_TX_IDLE[0];
		rx_idle = PH_RX_IDLE[0];
		n_fail = 0;
		n_items = 0;
		n_results = 0;
		n_raised = 0;
		n_due = 0;
		stall_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table under reset register values
		for (int i = 0; i < N_DIRECTED; i++)
			send_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			program_regs(16'(PH_WINDOW[p]), 8'(PH_PERIOD[p]));
			tx_idle = PH_TX_IDLE[p];
			rx_idle = PH_RX_IDLE[p];
			run_random(PHASE_ITEMS);
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d events and %0d results over %0d register settings",
			n_items, n_results, N_PHASES + 1);
		$display("Alarms raised %0d, status reports %0d, mismatches %0d",
			n_raised, n_due, n_fail);
		if (n_fail == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/iac_pkg.sv
rtl/iac_ifs.sv
rtl/iac_cfg.sv
rtl/iac_core.sv
rtl/intrusion_alarm_controller.sv
verif/tb_intrusion_alarm_controller.sv
